// File: rtl/mfpt_pkg.sv
package mfpt_pkg;

    // Field widths
    localparam int ANGLE_W = 16;
    localparam int RAW_W   = 16;
    localparam int TEMP_W  = 8;
    localparam int POS_W   = 48;
    localparam int SPD_W   = 32;
    localparam int CUR_W   = 15;

    // Input beat layout (s_tdata), lowest bit first
    localparam int IN_ANGLE_LSB   = 0;
    localparam int IN_RPM_LSB     = 16;
    localparam int IN_CUR_LSB     = 32;
    localparam int IN_TEMP_LSB    = 48;
    localparam int IN_CMD_POS_LSB = 56;
    localparam int IN_CMD_SPD_LSB = 104;
    localparam int S_DATA_W       = 136;

    // Output beat layout (m_tdata), lowest bit first
    localparam int OUT_POS_LSB    = 0;
    localparam int OUT_SPD_LSB    = 48;
    localparam int OUT_CUR_LSB    = 80;
    localparam int OUT_TEMP_LSB   = 95;
    localparam int OUT_PNEAR_BIT  = 103;
    localparam int OUT_SNEAR_BIT  = 104;
    localparam int OUT_USED_W     = 105;
    localparam int M_DATA_W       = 112;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 18;
    localparam int CPR_W       = 16;
    localparam int TRAVEL_W    = 18;
    localparam int LIMIT_W     = 16;

    localparam logic [CPR_W-1:0]    CPR_RESET       = 16'd8192;
    localparam logic [TRAVEL_W-1:0] TRAVEL_RESET    = 18'd6349;
    localparam logic [LIMIT_W-1:0]  POS_LIMIT_RESET = 16'd1280;
    localparam logic [LIMIT_W-1:0]  SPD_LIMIT_RESET = 16'd2560;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_COUNTS_PER_REV = 2'd0,
        CFG_TRAVEL_PER_REV = 2'd1,
        CFG_POS_NEAR_LIMIT = 2'd2,
        CFG_SPD_NEAR_LIMIT = 2'd3
    } cfg_index_t;

    // Speed scale: rpm to per-second
    localparam logic [CPR_W-1:0] SPEED_DIVISOR = 16'd60;

    // Largest current magnitude, 32768 * 5 / 16
    localparam logic signed [CUR_W-1:0] CUR_MAX = 15'sd10240;

    // Shared divider: two quotient bits per step
    localparam int DIV_W     = 34;
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DELTA,
        ST_UNWRAP,
        ST_MUL,
        ST_DIV_POS,
        ST_WAIT_POS,
        ST_ADD_POS,
        ST_WAIT_SPD,
        ST_DIFF,
        ST_NEAR,
        ST_PUBLISH
    } state_t;

    typedef struct packed {
        logic load;
        logic delta;
        logic zero;
        logic unwrap;
        logic mul;
        logic div_start;
        logic div_sel_spd;
        logic take_pos;
        logic add_pos;
        logic take_spd;
        logic diff;
        logic near;
        logic publish;
    } dp_cmd_t;

    typedef struct packed {
        logic op;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

// File: rtl/mfpt_div.sv
module mfpt_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [mfpt_pkg::DIV_W-1:0]   dividend,
    input  logic [mfpt_pkg::CPR_W-1:0]   divisor,
    output logic                         done,
    output logic [mfpt_pkg::DIV_W-1:0]   quotient,
    output logic                         round_up
);

    logic                             busy_reg;
    logic                             done_reg;
    logic [mfpt_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [mfpt_pkg::CPR_W-1:0]       rem_reg;
    logic [mfpt_pkg::CPR_W-1:0]       rem_next;
    logic [mfpt_pkg::DIV_W-1:0]       num_reg;
    logic [mfpt_pkg::DIV_W-1:0]       quo_reg;
    logic [mfpt_pkg::CPR_W-1:0]       dvsr_reg;
    logic [mfpt_pkg::CPR_W+1:0]       trial;
    logic [mfpt_pkg::CPR_W+1:0]       dv1;
    logic [mfpt_pkg::CPR_W+1:0]       dv2;
    logic [mfpt_pkg::CPR_W+1:0]       dv3;
    logic [1:0]                       digit;

    // Radix-4 restoring step: try 3, 2, 1 times the divisor
    always_comb begin
        trial = {rem_reg, num_reg[mfpt_pkg::DIV_W-1 -: 2]};
        dv1   = {2'b00, dvsr_reg};
        dv2   = {1'b0, dvsr_reg, 1'b0};
        dv3   = dv1 + dv2;
        if (trial >= dv3) begin
            digit    = 2'd3;
            rem_next = mfpt_pkg::CPR_W'(trial - dv3);
        end else if (trial >= dv2) begin
            digit    = 2'd2;
            rem_next = mfpt_pkg::CPR_W'(trial - dv2);
        end else if (trial >= dv1) begin
            digit    = 2'd1;
            rem_next = mfpt_pkg::CPR_W'(trial - dv1);
        end else begin
            digit    = 2'd0;
            rem_next = trial[mfpt_pkg::CPR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= mfpt_pkg::DIV_CNT_W'(mfpt_pkg::DIV_STEPS - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            num_reg  <= dividend;
            quo_reg  <= '0;
            dvsr_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            num_reg <= {num_reg[mfpt_pkg::DIV_W-3:0], 2'b00};
            quo_reg <= {quo_reg[mfpt_pkg::DIV_W-3:0], digit};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
    // Round half away from zero: bump when twice the remainder reaches the divisor
    assign round_up = {rem_reg, 1'b0} >= {1'b0, dvsr_reg};

endmodule

// File: rtl/mfpt_datapath.sv
module mfpt_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  mfpt_pkg::dp_cmd_t                 cmd,
    output mfpt_pkg::dp_status_t              status,
    input  logic [mfpt_pkg::S_DATA_W-1:0]     s_tdata,
    input  logic                              s_tuser,
    input  logic                              cfg_valid,
    input  logic [mfpt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mfpt_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [mfpt_pkg::M_DATA_W-1:0]     m_tdata
);

    // Configuration
    logic [mfpt_pkg::CPR_W-1:0]    cpr_reg;
    logic [mfpt_pkg::TRAVEL_W-1:0] travel_reg;
    logic [mfpt_pkg::LIMIT_W-1:0]  pos_lim_reg;
    logic [mfpt_pkg::LIMIT_W-1:0]  spd_lim_reg;
    logic [mfpt_pkg::CPR_W-1:0]    counts_eff;

    // Tracking state
    logic [mfpt_pkg::ANGLE_W-1:0]  prev_angle_reg;
    logic [mfpt_pkg::POS_W-1:0]    acc_reg;

    // Captured beat
    logic                          op_reg;
    logic [mfpt_pkg::ANGLE_W-1:0]  angle_in_reg;
    logic [mfpt_pkg::RAW_W-1:0]    rpm_in_reg;
    logic [mfpt_pkg::RAW_W-1:0]    cur_in_reg;
    logic [mfpt_pkg::TEMP_W-1:0]   temp_in_reg;
    logic [mfpt_pkg::POS_W-1:0]    cmd_pos_reg;
    logic [mfpt_pkg::SPD_W-1:0]    cmd_spd_reg;

    // Work registers
    logic [16:0]                   d_reg;
    logic [17:0]                   dadj_reg;
    logic                          dneg_reg;
    logic [mfpt_pkg::RAW_W-1:0]    rpm_mag_reg;
    logic                          rpm_neg_reg;
    logic [mfpt_pkg::RAW_W-1:0]    cur_mag_reg;
    logic                          cur_neg_reg;
    logic [mfpt_pkg::DIV_W-1:0]    prod_pos_reg;
    logic [mfpt_pkg::DIV_W-1:0]    prod_spd_reg;
    logic [mfpt_pkg::CUR_W-1:0]    cur_reg;
    logic [mfpt_pkg::POS_W-1:0]    inc_reg;
    logic [mfpt_pkg::SPD_W-1:0]    spd_reg;
    logic [mfpt_pkg::POS_W:0]      pdiff_reg;
    logic [mfpt_pkg::SPD_W:0]      sdiff_reg;
    logic                          pnear_reg;
    logic                          snear_reg;

    // Output register
    logic                          m_tvalid_reg;
    logic [mfpt_pkg::M_DATA_W-1:0] m_tdata_reg;
    logic [mfpt_pkg::M_DATA_W-1:0] m_tdata_next;

    // Combinational helpers
    logic [23:0]                   d24;
    logic [23:0]                   d100;
    logic [23:0]                   c66;
    logic [23:0]                   neg_c66;
    logic                          wrap_lo;
    logic                          wrap_hi;
    logic [17:0]                   d18;
    logic [17:0]                   c18;
    logic [17:0]                   dadj_next;
    logic [mfpt_pkg::RAW_W-1:0]    dmag;
    logic [mfpt_pkg::DIV_W-1:0]    prod_pos_next;
    logic [mfpt_pkg::DIV_W-1:0]    prod_spd_next;
    logic [17:0]                   cur5;
    logic [13:0]                   cur_rnd;
    logic [mfpt_pkg::CUR_W-1:0]    cur_next;
    logic [mfpt_pkg::DIV_W-1:0]    div_dividend;
    logic [mfpt_pkg::CPR_W-1:0]    div_divisor;
    logic                          div_done;
    logic [mfpt_pkg::DIV_W-1:0]    div_quo;
    logic                          div_rnd;
    logic [mfpt_pkg::DIV_W:0]      q_pos;
    logic [mfpt_pkg::DIV_W:0]      q_neg;
    logic [mfpt_pkg::POS_W:0]      psum;
    logic [mfpt_pkg::SPD_W:0]      ssum;
    logic                          pnear_next;
    logic                          snear_next;

    assign counts_eff = (cpr_reg == '0) ? mfpt_pkg::CPR_W'(1) : cpr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpr_reg     <= mfpt_pkg::CPR_RESET;
            travel_reg  <= mfpt_pkg::TRAVEL_RESET;
            pos_lim_reg <= mfpt_pkg::POS_LIMIT_RESET;
            spd_lim_reg <= mfpt_pkg::SPD_LIMIT_RESET;
        end else if (cfg_valid) begin
            case (mfpt_pkg::cfg_index_t'(cfg_index))
                mfpt_pkg::CFG_COUNTS_PER_REV: cpr_reg     <= cfg_data[mfpt_pkg::CPR_W-1:0];
                mfpt_pkg::CFG_TRAVEL_PER_REV: travel_reg  <= cfg_data;
                mfpt_pkg::CFG_POS_NEAR_LIMIT: pos_lim_reg <= cfg_data[mfpt_pkg::LIMIT_W-1:0];
                mfpt_pkg::CFG_SPD_NEAR_LIMIT: spd_lim_reg <= cfg_data[mfpt_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_angle_reg <= '0;
            acc_reg        <= '0;
        end else begin
            if (cmd.delta) begin
                prev_angle_reg <= angle_in_reg;
            end
            if (cmd.zero) begin
                acc_reg <= '0;
            end else if (cmd.add_pos) begin
                acc_reg <= acc_reg + inc_reg;
            end
        end
    end

    // Unwrap: pull back by one revolution past 0.66 of a turn either way
    always_comb begin
        d24       = {{7{d_reg[16]}}, d_reg};
        d100      = (d24 << 6) + (d24 << 5) + (d24 << 2);
        c66       = ({8'd0, counts_eff} << 6) + ({8'd0, counts_eff} << 1);
        neg_c66   = -c66;
        wrap_lo   = $signed(d100) < $signed(neg_c66);
        wrap_hi   = $signed(d100) > $signed(c66);
        d18       = {d_reg[16], d_reg};
        c18       = {2'b00, counts_eff};
        if (wrap_lo) begin
            dadj_next = d18 + c18;
        end else if (wrap_hi) begin
            dadj_next = d18 - c18;
        end else begin
            dadj_next = d18;
        end
    end

    always_comb begin
        dmag          = dadj_reg[17] ? mfpt_pkg::RAW_W'(-dadj_reg) : dadj_reg[15:0];
        prod_pos_next = mfpt_pkg::DIV_W'(dmag) * mfpt_pkg::DIV_W'(travel_reg);
        prod_spd_next = mfpt_pkg::DIV_W'(rpm_mag_reg) * mfpt_pkg::DIV_W'(travel_reg);
        cur5          = {cur_mag_reg, 2'b00} + {2'b00, cur_mag_reg};
        cur_rnd       = 14'((cur5 + 18'd8) >> 4);
        cur_next      = cur_neg_reg ? mfpt_pkg::CUR_W'(-{1'b0, cur_rnd}) : {1'b0, cur_rnd};
    end

    assign div_dividend = cmd.div_sel_spd ? prod_spd_reg : prod_pos_reg;
    assign div_divisor  = cmd.div_sel_spd ? mfpt_pkg::SPEED_DIVISOR : counts_eff;

    mfpt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo),
        .round_up (div_rnd)
    );

    // Signed rounded quotient in one add: -(q + r) == ~q + !r
    assign q_pos = {1'b0, div_quo} + (mfpt_pkg::DIV_W + 1)'(div_rnd);
    assign q_neg = ~{1'b0, div_quo} + (mfpt_pkg::DIV_W + 1)'(!div_rnd);

    // Near: |x| < L, for negative x that is x + L > 0
    always_comb begin
        psum       = pdiff_reg + {(mfpt_pkg::POS_W + 1 - mfpt_pkg::LIMIT_W)'(0), pos_lim_reg};
        ssum       = sdiff_reg + {(mfpt_pkg::SPD_W + 1 - mfpt_pkg::LIMIT_W)'(0), spd_lim_reg};
        pnear_next = pdiff_reg[mfpt_pkg::POS_W]
            ? (!psum[mfpt_pkg::POS_W] && (psum != '0))
            : (pdiff_reg < {(mfpt_pkg::POS_W + 1 - mfpt_pkg::LIMIT_W)'(0), pos_lim_reg});
        snear_next = sdiff_reg[mfpt_pkg::SPD_W]
            ? (!ssum[mfpt_pkg::SPD_W] && (ssum != '0))
            : (sdiff_reg < {(mfpt_pkg::SPD_W + 1 - mfpt_pkg::LIMIT_W)'(0), spd_lim_reg});
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg       <= s_tuser;
            angle_in_reg <= s_tdata[mfpt_pkg::IN_ANGLE_LSB +: mfpt_pkg::ANGLE_W];
            rpm_in_reg   <= s_tdata[mfpt_pkg::IN_RPM_LSB +: mfpt_pkg::RAW_W];
            cur_in_reg   <= s_tdata[mfpt_pkg::IN_CUR_LSB +: mfpt_pkg::RAW_W];
            temp_in_reg  <= s_tdata[mfpt_pkg::IN_TEMP_LSB +: mfpt_pkg::TEMP_W];
            cmd_pos_reg  <= s_tdata[mfpt_pkg::IN_CMD_POS_LSB +: mfpt_pkg::POS_W];
            cmd_spd_reg  <= s_tdata[mfpt_pkg::IN_CMD_SPD_LSB +: mfpt_pkg::SPD_W];
        end
        if (cmd.delta) begin
            d_reg       <= {angle_in_reg[15], angle_in_reg} - {prev_angle_reg[15], prev_angle_reg};
            rpm_neg_reg <= rpm_in_reg[15];
            rpm_mag_reg <= rpm_in_reg[15] ? -rpm_in_reg : rpm_in_reg;
            cur_neg_reg <= cur_in_reg[15];
            cur_mag_reg <= cur_in_reg[15] ? -cur_in_reg : cur_in_reg;
        end
        if (cmd.unwrap) begin
            dadj_reg <= dadj_next;
        end
        if (cmd.mul) begin
            dneg_reg     <= dadj_reg[17];
            prod_pos_reg <= prod_pos_next;
            prod_spd_reg <= prod_spd_next;
            cur_reg      <= cur_next;
        end
        if (cmd.take_pos) begin
            inc_reg <= dneg_reg
                ? {{(mfpt_pkg::POS_W - mfpt_pkg::DIV_W - 1){q_neg[mfpt_pkg::DIV_W]}}, q_neg}
                : {{(mfpt_pkg::POS_W - mfpt_pkg::DIV_W - 1){1'b0}}, q_pos};
        end
        if (cmd.take_spd) begin
            spd_reg <= rpm_neg_reg ? q_neg[mfpt_pkg::SPD_W-1:0] : q_pos[mfpt_pkg::SPD_W-1:0];
        end
        if (cmd.diff) begin
            pdiff_reg <= {acc_reg[mfpt_pkg::POS_W-1], acc_reg}
                       - {cmd_pos_reg[mfpt_pkg::POS_W-1], cmd_pos_reg};
            sdiff_reg <= {spd_reg[mfpt_pkg::SPD_W-1], spd_reg}
                       - {cmd_spd_reg[mfpt_pkg::SPD_W-1], cmd_spd_reg};
        end
        if (cmd.near) begin
            pnear_reg <= pnear_next;
            snear_reg <= snear_next;
        end
    end

    // Zero operation reports an all-zero beat
    assign m_tdata_next = op_reg ? '0 :
        {(mfpt_pkg::M_DATA_W - mfpt_pkg::OUT_USED_W)'(0),
         snear_reg, pnear_reg, temp_in_reg, cur_reg, spd_reg, acc_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.publish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = m_tdata_reg;
    assign status.op       = op_reg;
    assign status.div_done = div_done;
    assign status.out_free = !m_tvalid_reg || m_tready;

endmodule

// File: rtl/mfpt_ctrl.sv
module mfpt_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  mfpt_pkg::dp_status_t  status,
    output mfpt_pkg::dp_cmd_t     cmd
);

    mfpt_pkg::state_t state_reg;
    mfpt_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mfpt_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            mfpt_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = mfpt_pkg::ST_DELTA;
                end
            end
            mfpt_pkg::ST_DELTA: begin
                if (status.op) begin
                    cmd.zero   = 1'b1;
                    state_next = mfpt_pkg::ST_PUBLISH;
                end else begin
                    cmd.delta  = 1'b1;
                    state_next = mfpt_pkg::ST_UNWRAP;
                end
            end
            mfpt_pkg::ST_UNWRAP: begin
                cmd.unwrap = 1'b1;
                state_next = mfpt_pkg::ST_MUL;
            end
            mfpt_pkg::ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = mfpt_pkg::ST_DIV_POS;
            end
            mfpt_pkg::ST_DIV_POS: begin
                cmd.div_start = 1'b1;
                state_next    = mfpt_pkg::ST_WAIT_POS;
            end
            mfpt_pkg::ST_WAIT_POS: begin
                if (status.div_done) begin
                    // Take the position quotient and start the speed pass
                    cmd.take_pos    = 1'b1;
                    cmd.div_start   = 1'b1;
                    cmd.div_sel_spd = 1'b1;
                    state_next      = mfpt_pkg::ST_ADD_POS;
                end
            end
            mfpt_pkg::ST_ADD_POS: begin
                cmd.add_pos = 1'b1;
                state_next  = mfpt_pkg::ST_WAIT_SPD;
            end
            mfpt_pkg::ST_WAIT_SPD: begin
                if (status.div_done) begin
                    cmd.take_spd = 1'b1;
                    state_next   = mfpt_pkg::ST_DIFF;
                end
            end
            mfpt_pkg::ST_DIFF: begin
                cmd.diff   = 1'b1;
                state_next = mfpt_pkg::ST_NEAR;
            end
            mfpt_pkg::ST_NEAR: begin
                cmd.near   = 1'b1;
                state_next = mfpt_pkg::ST_PUBLISH;
            end
            mfpt_pkg::ST_PUBLISH: begin
                if (status.out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = mfpt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mfpt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/motor_feedback_position_tracker.sv
// Feedback frame: two passes through the shared radix-4 divider lie between the accepted
// input beat and m_tvalid; the next input beat is taken only after the frame is published.
// Zero operation: skips the arithmetic and goes from the input beat straight to publishing.
// A result that is not taken stalls only the final write into the output register.
// aresetn is synchronous, active low: it restores the configuration reset values,
// clears the previous angle and the accumulated position, and drops m_tvalid.
module motor_feedback_position_tracker (
    input  logic                              aclk,
    input  logic                              aresetn,

    // Input beat
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // raw_angle[15:0], raw_rpm[31:16], raw_current[47:32], raw_temperature[55:48],
    // commanded_position[103:56], commanded_speed[135:104]
    input  logic [mfpt_pkg::S_DATA_W-1:0]     s_tdata,
    // op[0]: 0 feedback frame, 1 zero the accumulated position
    input  logic                              s_tuser,

    // Result beat
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // position[47:0], speed[79:48], current[94:80], temperature[102:95],
    // position_near[103], speed_near[104], zero fill[111:105]
    output logic [mfpt_pkg::M_DATA_W-1:0]     m_tdata,

    // Register writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mfpt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mfpt_pkg::CFG_DATA_W-1:0]   cfg_data
);

    mfpt_pkg::dp_cmd_t    cmd;
    mfpt_pkg::dp_status_t status;

    // Registers are plain flops; a write always lands the same cycle.
    assign cfg_ready = 1'b1;

    // Sequencer: walks one frame through delta, unwrap, multiply,
    // two divider passes, accumulate, near checks and the output register.
    mfpt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: configuration, tracking state, arithmetic and the result register.
    mfpt_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

// File: rtl/mfpt_checker.sv
module mfpt_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mfpt_pkg::M_DATA_W-1:0] m_tdata
);

    // A stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Reset drops the result
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // One frame at a time: busy right after taking a beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a frame is in flight");

    // Current stays within the 5/16 scale of the raw code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |->
            ($signed(m_tdata[mfpt_pkg::OUT_CUR_LSB +: mfpt_pkg::CUR_W]) <= mfpt_pkg::CUR_MAX) &&
            ($signed(m_tdata[mfpt_pkg::OUT_CUR_LSB +: mfpt_pkg::CUR_W]) >= -mfpt_pkg::CUR_MAX))
        else $error("current out of range");

    // Fill bits above the fields stay zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[mfpt_pkg::M_DATA_W-1:mfpt_pkg::OUT_USED_W] == '0)
        else $error("fill bits set in result beat");

endmodule

bind motor_feedback_position_tracker mfpt_checker u_mfpt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/sv/tb.sv
module tb;
    import mfpt_pkg::*;

    // Operation carried on s_tuser
    localparam logic OP_FEEDBACK = 1'b0;
    localparam logic OP_ZERO     = 1'b1;

    // End the run after this many cycles without any beat on any channel
    localparam int QUIET_LIMIT = 2000;

    localparam logic signed [POS_W-1:0] CMD_POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] CMD_POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic signed [SPD_W-1:0] CMD_SPD_MAX = {1'b0, {(SPD_W-1){1'b1}}};
    localparam logic signed [SPD_W-1:0] CMD_SPD_MIN = {1'b1, {(SPD_W-1){1'b0}}};

    // Input beat, laid out exactly as s_tdata (last member in the lowest bits)
    typedef struct packed {
        logic signed [SPD_W-1:0]   cmd_spd;
        logic signed [POS_W-1:0]   cmd_pos;
        logic [TEMP_W-1:0]         temperature;
        logic signed [RAW_W-1:0]   current;
        logic signed [RAW_W-1:0]   rpm;
        logic signed [ANGLE_W-1:0] angle;
    } frame_t;

    // Result beat, laid out exactly as the used bits of m_tdata
    typedef struct packed {
        logic                    spd_near;
        logic                    pos_near;
        logic [TEMP_W-1:0]       temperature;
        logic signed [CUR_W-1:0] current;
        logic signed [SPD_W-1:0] speed;
        logic signed [POS_W-1:0] position;
    } feedback_t;

    // Every input starts at a known value; reset is held from time zero
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Tracker's own copy of the registers and of the rotor state
    logic [CPR_W-1:0]            cpr_reg      = CPR_RESET;
    logic [TRAVEL_W-1:0]         travel_reg   = TRAVEL_RESET;
    logic [LIMIT_W-1:0]          pos_band     = POS_LIMIT_RESET;
    logic [LIMIT_W-1:0]          spd_band     = SPD_LIMIT_RESET;
    logic signed [ANGLE_W-1:0]   last_angle   = '0;
    logic signed [POS_W-1:0]     position_acc = '0;

    // Feedback beats owed by the block, oldest first
    feedback_t pending_feedback[$];

    int mismatches    = 0;
    int quiet_cycles  = 0;
    int send_idle_pct = 0;
    int sink_idle_pct = 0;
    int sink_hold     = 0;

    motor_feedback_position_tracker u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Tracking arithmetic
    // ------------------------------------------------------------------

    // Divide and round to nearest, ties away from zero; den is positive
    function automatic longint round_div(input longint num, input longint den);
        if (num >= 0)
            return (2 * num + den) / (2 * den);
        return -((2 * (-num) + den) / (2 * den));
    endfunction

    // Position after a frame at this angle, without committing it
    function automatic logic signed [POS_W-1:0] advance_position(
        input logic signed [ANGLE_W-1:0] angle
    );
        longint cpr;
        longint d;
        // a zero count per revolution behaves as one count
        cpr = (cpr_reg == '0) ? 64'sd1 : longint'(cpr_reg);
        d = longint'(angle) - longint'(last_angle);
        // unwrap a jump beyond 0.66 of a revolution, once
        if (100 * d < -66 * cpr)
            d = d + cpr;
        if (100 * d > 66 * cpr)
            d = d - cpr;
        return position_acc + POS_W'(round_div(d * longint'(travel_reg), cpr));
    endfunction

    function automatic logic signed [SPD_W-1:0] scaled_speed(
        input logic signed [RAW_W-1:0] rpm
    );
        return SPD_W'(round_div(longint'(rpm) * longint'(travel_reg), 60));
    endfunction

    // Commit one accepted beat to the tracker state and return its feedback
    function automatic feedback_t track_frame(input logic op, input frame_t f);
        feedback_t r;
        longint    pos_err;
        longint    spd_err;
        r = '0;
        if (op == OP_ZERO) begin
            // clear the position, keep the last angle, all fields read zero
            position_acc = '0;
            return r;
        end
        position_acc  = advance_position(f.angle);
        last_angle    = f.angle;
        r.position    = position_acc;
        r.speed       = scaled_speed(f.rpm);
        r.current     = CUR_W'(round_div(longint'($signed(f.current)) * 5, 16));
        r.temperature = f.temperature;
        // exact differences, no wrap
        pos_err = longint'(r.position) - longint'($signed(f.cmd_pos));
        spd_err = longint'(r.speed) - longint'($signed(f.cmd_spd));
        if (pos_err < 0)
            pos_err = -pos_err;
        if (spd_err < 0)
            spd_err = -spd_err;
        r.pos_near = (pos_err < longint'(pos_band));
        r.spd_near = (spd_err < longint'(spd_band));
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    // Offset that lands on both sides of a near band
    function automatic int near_offset(input int band);
        return int'($urandom_range(0, 4 * band + 2)) - (2 * band + 1);
    endfunction

    function automatic frame_t frame_of(
        input logic signed [RAW_W-1:0] angle,
        input logic signed [RAW_W-1:0] rpm,
        input logic signed [RAW_W-1:0] current,
        input logic [TEMP_W-1:0]       temperature,
        input logic signed [POS_W-1:0] cmd_pos,
        input logic signed [SPD_W-1:0] cmd_spd
    );
        frame_t f;
        f.angle       = angle;
        f.rpm         = rpm;
        f.current     = current;
        f.temperature = temperature;
        f.cmd_pos     = cmd_pos;
        f.cmd_spd     = cmd_spd;
        return f;
    endfunction

    function automatic frame_t random_frame();
        frame_t f;
        int     span;
        int     step;
        f.rpm         = RAW_W'($urandom);
        f.current     = RAW_W'($urandom);
        f.temperature = TEMP_W'($urandom);
        f.cmd_pos     = POS_W'({$urandom, $urandom});
        f.cmd_spd     = SPD_W'($urandom);
        if ($urandom_range(0, 99) < 80) begin
            // follow the rotor: small moves and moves around the unwrap threshold
            span = (cpr_reg == '0) ? 1 : int'(cpr_reg);
            if ($urandom_range(0, 1))
                step = $urandom_range(0, span / 4);
            else
                step = span * 60 / 100 + $urandom_range(0, span * 12 / 100);
            if ($urandom_range(0, 1))
                step = -step;
            f.angle = ANGLE_W'(int'(last_angle) + step);
            // aim the commands at the result often enough to flip the near flags
            if ($urandom_range(0, 99) < 40)
                f.cmd_pos = advance_position(f.angle) + POS_W'(near_offset(pos_band));
            if ($urandom_range(0, 99) < 40)
                f.cmd_spd = scaled_speed(f.rpm) + SPD_W'(near_offset(spd_band));
        end else begin
            f.angle = ANGLE_W'($urandom);
        end
        return f;
    endfunction

    // Offer one beat and hold it until accepted. Keep tvalid high for a
    // back-to-back beat; lower it only when a gap comes first.
    task automatic send_frame(input logic op, input frame_t f);
        int gap;
        gap = ($urandom_range(0, 99) < send_idle_pct) ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= f;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        pending_feedback.push_back(track_frame(op, f));
    endtask

    // Pause the sender until every owed beat has come back, then settle
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_feedback.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_COUNTS_PER_REV: cpr_reg    = value[CPR_W-1:0];
            CFG_TRAVEL_PER_REV: travel_reg = value[TRAVEL_W-1:0];
            CFG_POS_NEAR_LIMIT: pos_band   = value[LIMIT_W-1:0];
            CFG_SPD_NEAR_LIMIT: spd_band   = value[LIMIT_W-1:0];
            default: ;
        endcase
        // drop valid before the next write so it starts on a fresh edge
        @(posedge aclk);
    endtask

    // Registers change only while the block is idle
    task automatic apply_settings(
        input logic [CPR_W-1:0]    cpr,
        input logic [TRAVEL_W-1:0] travel,
        input logic [LIMIT_W-1:0]  pband,
        input logic [LIMIT_W-1:0]  sband
    );
        wait_results_drained();
        write_reg(CFG_COUNTS_PER_REV, CFG_DATA_W'(cpr));
        write_reg(CFG_TRAVEL_PER_REV, CFG_DATA_W'(travel));
        write_reg(CFG_POS_NEAR_LIMIT, CFG_DATA_W'(pband));
        write_reg(CFG_SPD_NEAR_LIMIT, CFG_DATA_W'(sband));
    endtask

    task automatic run_random_items(input int count, input int pause_every);
        for (int i = 0; i < count; i++) begin
            if (pause_every > 0 && i % pause_every == pause_every - 1)
                wait_results_drained();
            send_frame(($urandom_range(0, 99) < 5) ? OP_ZERO : OP_FEEDBACK, random_frame());
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, rounding ties, the zero operation and both band edges
    // under the reset register values
    task automatic test_default_registers();
        logic signed [ANGLE_W-1:0] a;
        send_idle_pct = 0;
        sink_idle_pct = 0;
        send_frame(OP_FEEDBACK, frame_of(16'sd0, 16'sd0, 16'sd0, 8'h00, '0, '0));
        send_frame(OP_FEEDBACK, frame_of(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 8'hFF,
                                         CMD_POS_MAX, CMD_SPD_MAX));
        send_frame(OP_FEEDBACK, frame_of(16'sh8000, 16'sh8000, 16'sh8000, 8'h00,
                                         CMD_POS_MIN, CMD_SPD_MIN));
        // current ties at +/-2.5 and a speed tie at 3174.5 round away from zero
        send_frame(OP_FEEDBACK, frame_of(16'sd8, 16'sd1, 16'sd8, 8'h55, '0, '0));
        send_frame(OP_FEEDBACK, frame_of(-16'sd8, -16'sd1, -16'sd8, 8'hAA, '0, '0));
        send_frame(OP_FEEDBACK, frame_of(16'sd1, 16'sd30, -16'sd1, 8'h01, '0, '0));
        send_frame(OP_ZERO, frame_of(16'sh1234, 16'sd500, 16'sd500, 8'h80, '0, '0));
        // hold the angle so position stays zero; walk the position band edges
        a = last_angle;
        send_frame(OP_FEEDBACK, frame_of(a, 16'sd0, 16'sd0, 8'h00,
                                         POS_W'(int'(pos_band) - 1), '0));
        send_frame(OP_FEEDBACK, frame_of(a, 16'sd0, 16'sd0, 8'h00,
                                         POS_W'(int'(pos_band)), '0));
        send_frame(OP_FEEDBACK, frame_of(a, 16'sd0, 16'sd0, 8'h00,
                                         POS_W'(1 - int'(pos_band)), '0));
        // speed band edges at 1000 rpm
        send_frame(OP_FEEDBACK, frame_of(a, 16'sd1000, 16'sd0, 8'h00, '0,
            scaled_speed(16'sd1000) + SPD_W'(int'(spd_band) - 1)));
        send_frame(OP_FEEDBACK, frame_of(a, 16'sd1000, 16'sd0, 8'h00, '0,
            scaled_speed(16'sd1000) + SPD_W'(int'(spd_band))));
        send_frame(OP_FEEDBACK, frame_of(a, 16'sd1000, 16'sd0, 8'h00, '0,
            scaled_speed(16'sd1000) - SPD_W'(int'(spd_band))));
        // a plain move, then one past the unwrap threshold
        send_frame(OP_FEEDBACK, frame_of(a + 16'sd2000, 16'sd0, 16'sd0, 8'h00, '0, '0));
        send_frame(OP_FEEDBACK, frame_of(a + 16'sd8000, 16'sd0, 16'sd0, 8'h00, '0, '0));
    endtask

    // Unwrap exactly at and one count past 0.66 of a revolution, both ways,
    // then a zero count per revolution
    task automatic test_unwrap_and_zero_counts();
        apply_settings(16'd100, 18'd256, 16'hFFFF, 16'h0000);
        send_frame(OP_FEEDBACK, frame_of(16'sd0, 16'sd7, 16'sd3, 8'h10, '0, '0));
        send_frame(OP_FEEDBACK, frame_of(16'sd66, 16'sd7, 16'sd3, 8'h11, '0, '0));
        send_frame(OP_FEEDBACK, frame_of(16'sd133, 16'sd7, 16'sd3, 8'h12, '0, '0));
        send_frame(OP_FEEDBACK, frame_of(16'sd67, 16'sd7, 16'sd3, 8'h13, '0, '0));
        send_frame(OP_FEEDBACK, frame_of(16'sd0, 16'sd7, 16'sd3, 8'h14, '0, '0));
        apply_settings(16'd0, 18'd1000, 16'd300, 16'd300);
        send_frame(OP_FEEDBACK, frame_of(16'sd5, 16'sd7, 16'sd3, 8'h15, '0, '0));
        send_frame(OP_FEEDBACK, frame_of(-16'sd3, 16'sd7, 16'sd3, 8'h16, '0, '0));
    endtask

    // Random rotor traffic over several register settings and idle mixes
    task automatic test_random_settings();
        apply_settings(16'hFFFF, 18'h3FFFF, 16'hFFFF, 16'hFFFF);
        send_idle_pct = 0;
        sink_idle_pct = 0;
        run_random_items(180, 0);

        apply_settings(16'd1, 18'd0, 16'd0, 16'd0);
        send_idle_pct = 30;
        sink_idle_pct = 30;
        run_random_items(180, 0);

        apply_settings(CPR_RESET, TRAVEL_RESET, POS_LIMIT_RESET, SPD_LIMIT_RESET);
        send_idle_pct = 10;
        sink_idle_pct = 50;
        run_random_items(180, 0);

        apply_settings(16'd4096, TRAVEL_W'($urandom), LIMIT_W'($urandom_range(0, 4096)),
                       LIMIT_W'($urandom_range(0, 4096)));
        send_idle_pct = 50;
        sink_idle_pct = 10;
        run_random_items(180, 0);

        apply_settings(CPR_W'($urandom), TRAVEL_W'($urandom), LIMIT_W'($urandom),
                       LIMIT_W'($urandom));
        send_idle_pct = 20;
        sink_idle_pct = 20;
        run_random_items(180, 0);

        apply_settings(CPR_W'($urandom_range(1, 255)), TRAVEL_W'($urandom),
                       LIMIT_W'($urandom), LIMIT_W'($urandom));
        send_idle_pct = 0;
        sink_idle_pct = 40;
        run_random_items(180, 0);
    endtask

    // Hold the result side off for a long stretch while beats keep coming,
    // so the block fills and stalls its input
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        sink_idle_pct = 20;
        sink_hold     = 300;
        run_random_items(12, 0);
    endtask

    // Stop sending now and then until every result is back
    task automatic test_pause_until_drained();
        send_idle_pct = 20;
        sink_idle_pct = 20;
        run_random_items(60, 12);
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Drive m_tready: honor a long hold first, then random stalls
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (sink_hold > 0) begin
                m_tready <= 1'b0;
                repeat (sink_hold) @(posedge aclk);
                sink_hold = 0;
                m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 99) < sink_idle_pct) begin
                m_tready <= 1'b0;
                stall_left = pick_gap() - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    // Check every accepted result beat against the oldest owed one
    always @(posedge aclk) begin : result_check
        feedback_t want;
        feedback_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[OUT_USED_W-1:0];
            if (pending_feedback.size() == 0) begin
                mismatches++;
                $display("%0t unexpected result beat: expected none actual %0h",
                         $time, m_tdata);
            end else begin
                want = pending_feedback.pop_front();
                compare_field("position", $unsigned(want.position), $unsigned(got.position));
                compare_field("speed", $unsigned(want.speed), $unsigned(got.speed));
                compare_field("current", $unsigned(want.current), $unsigned(got.current));
                compare_field("temperature", want.temperature, got.temperature);
                compare_field("position_near", want.pos_near, got.pos_near);
                compare_field("speed_near", want.spd_near, got.spd_near);
            end
        end
    end

    // Stop a hung run: count cycles with no beat on any channel
    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t watchdog: no beat for %0d cycles, %0d results owed",
                         $time, quiet_cycles, pending_feedback.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_registers();
        test_unwrap_and_zero_counts();
        test_random_settings();
        test_output_backpressure();
        test_pause_until_drained();

        // collect the tail, then watch a while for stray beats
        wait_results_drained();
        repeat (50) @(posedge aclk);

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
